// ----- design/kirchhoff_surface_integral_accumulator_unit_defines.svh -----
// Assertion helpers, clocked on clk_i and held off during reset.
`ifndef KIRCHHOFF_SURFACE_INTEGRAL_ACCUMULATOR_UNIT_DEFINES_SVH
`define KIRCHHOFF_SURFACE_INTEGRAL_ACCUMULATOR_UNIT_DEFINES_SVH

// Same-cycle implication.
`define KSIA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define KSIA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/ksia_pkg.sv -----
package ksia_pkg;

  localparam int FRAC_BITS  = 32;
  localparam int COUNT_BITS = 24;

  // Divider runs over the shifted numerator, square root over 64 result bits.
  localparam int ALU_NW = 64 + FRAC_BITS;
  localparam int ALU_CW = $clog2(ALU_NW);

  localparam logic [63:0] K_RAW = 64'hA2F9836E4E441529;
  localparam logic [63:0] K_RND = (K_RAW + (64'd1 << (66 - FRAC_BITS))) >> (67 - FRAC_BITS);
  localparam logic signed [63:0] K_FIX = $signed(K_RND);

  localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

  typedef enum logic [1:0] {
    ALU_WMUL,
    ALU_FMUL,
    ALU_DIV,
    ALU_SQRT
  } alu_op_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } alu_rsp_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CALC,
    S_FIN
  } state_e;

  typedef enum logic [4:0] {
    ST_SQX, ST_SQY, ST_SQZ, ST_SQRT, ST_RC, ST_CHK,
    ST_DOTX, ST_DOTY, ST_DOTZ, ST_CS,
    ST_PT, ST_PP, ST_PNA, ST_PNB,
    ST_AA, ST_AB, ST_T1,
    ST_T2A, ST_T2B, ST_T2C,
    ST_KM, ST_TERM
  } step_e;

  typedef enum logic [2:0] {
    REG_OBS_X, REG_OBS_Y, REG_OBS_Z, REG_OBS_T,
    REG_INV_C, REG_WIN_START, REG_WIN_END, REG_INV_WLEN
  } reg_idx_e;

  function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) s = a[63] ? S64_MIN : S64_MAX;
    return s;
  endfunction

  function automatic logic signed [63:0] ssub(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a - b;
    if (a[63] != b[63] && s[63] != a[63]) s = a[63] ? S64_MIN : S64_MAX;
    return s;
  endfunction

endpackage

// ----- design/ksia_if.sv -----
interface ksia_in_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] point_x;
  logic signed [47:0] point_y;
  logic signed [47:0] point_z;
  logic signed [47:0] normal_x;
  logic signed [47:0] normal_y;
  logic signed [47:0] normal_z;
  logic        [46:0] area_weight;
  logic signed [47:0] p_now;
  logic signed [47:0] p_next;
  logic signed [47:0] pn_now;
  logic signed [47:0] pn_next;
  logic               last_point;

  modport source (output valid, point_x, point_y, point_z, normal_x, normal_y, normal_z,
                  area_weight, p_now, p_next, pn_now, pn_next, last_point,
                  input ready);
  modport sink (input valid, point_x, point_y, point_z, normal_x, normal_y, normal_z,
                area_weight, p_now, p_next, pn_now, pn_next, last_point,
                output ready);
endinterface

interface ksia_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] partial_integral;
  logic        [23:0] points_counted;

  modport source (output valid, partial_integral, points_counted, input ready);
  modport sink (input valid, partial_integral, points_counted, output ready);
endinterface

// ----- design/ksia_alu.sv -----
module ksia_alu (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ksia_pkg::alu_req_t   req_i,
  input  logic signed [63:0]   a_i,
  input  logic signed [63:0]   b_i,
  input  logic        [127:0]  rad_i,
  output ksia_pkg::alu_rsp_t   rsp_o,
  output logic signed [63:0]   res_o,
  output logic        [127:0]  prod_o
);

  localparam int NW = ksia_pkg::ALU_NW;
  localparam int CW = ksia_pkg::ALU_CW;
  localparam int FB = ksia_pkg::FRAC_BITS;

  logic                busy_q, fin_q;
  ksia_pkg::alu_op_e   op_q;
  logic                neg_q;
  logic [63:0]         ua_q, ub_q;
  logic [127:0]        acc_q, sh_q;
  logic [66:0]         rem_q;
  logic [63:0]         pp_q;
  logic [CW-1:0]       cnt_q;

  logic [63:0]  ma, mb;
  logic [31:0]  fa, fb;
  logic [1:0]   prev;
  logic [127:0] ppv;
  logic [64:0]  dt;
  logic         dge;
  logic [66:0]  st, strial;
  logic         sge;
  logic         last;

  function automatic logic signed [63:0] from_mag(input logic neg, input logic hi_nz,
                                                  input logic [63:0] q, input logic bump);
    logic [63:0] lim;
    logic        sat;
    lim = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    sat = hi_nz || (bump ? (q >= lim) : (q > lim));
    if (sat) return neg ? ksia_pkg::S64_MIN : ksia_pkg::S64_MAX;
    if (!neg) return $signed(q);
    return bump ? $signed(~q) : $signed(-q);
  endfunction

  assign ma = a_i[63] ? 64'(-a_i) : 64'(a_i);
  assign mb = b_i[63] ? 64'(-b_i) : 64'(b_i);

  // Partial product order: lo*lo, lo*hi, hi*lo, hi*hi.
  always_comb begin
    fa = cnt_q[1] ? ua_q[63:32] : ua_q[31:0];
    fb = cnt_q[0] ? ub_q[63:32] : ub_q[31:0];
    prev = 2'(cnt_q - CW'(1));
    case (prev)
      2'd0:    ppv = {64'd0, pp_q};
      2'd3:    ppv = {pp_q, 64'd0};
      default: ppv = {32'd0, pp_q, 32'd0};
    endcase
  end

  assign dt  = {rem_q[63:0], sh_q[127]};
  assign dge = dt >= {1'b0, ub_q};
  assign st     = {rem_q[64:0], sh_q[127:126]};
  assign strial = {1'b0, acc_q[63:0], 2'b01};
  assign sge    = st >= strial;

  always_comb begin
    unique case (op_q)
      ksia_pkg::ALU_DIV:  last = (cnt_q == CW'(NW - 1));
      ksia_pkg::ALU_SQRT: last = (cnt_q == CW'(63));
      default:            last = (cnt_q == CW'(4));
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      op_q   <= ksia_pkg::ALU_WMUL;
      cnt_q  <= '0;
    end else begin
      fin_q <= 1'b0;
      if (req_i.start && !busy_q) begin
        busy_q <= 1'b1;
        op_q   <= req_i.op;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (last) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start && !busy_q) begin
      ua_q  <= ma;
      ub_q  <= mb;
      neg_q <= (req_i.op == ksia_pkg::ALU_DIV) ? a_i[63] : (a_i[63] ^ b_i[63]);
      acc_q <= '0;
      rem_q <= '0;
      sh_q  <= (req_i.op == ksia_pkg::ALU_SQRT) ? rad_i : {ma, 64'd0};
    end else if (busy_q) begin
      unique case (op_q)
        ksia_pkg::ALU_DIV: begin
          rem_q <= {3'd0, dge ? 64'(dt - {1'b0, ub_q}) : dt[63:0]};
          acc_q <= {acc_q[126:0], dge};
          sh_q  <= {sh_q[126:0], 1'b0};
        end
        ksia_pkg::ALU_SQRT: begin
          rem_q <= sge ? (st - strial) : st;
          acc_q <= {acc_q[126:0], sge};
          sh_q  <= {sh_q[125:0], 2'b00};
        end
        default: begin
          if (cnt_q < CW'(4)) pp_q <= fa * fb;
          if (cnt_q != '0) acc_q <= acc_q + ppv;
        end
      endcase
    end
  end

  always_comb begin
    unique case (op_q)
      ksia_pkg::ALU_DIV:
        res_o = from_mag(neg_q, |acc_q[127:64], acc_q[63:0], neg_q && (rem_q != '0));
      ksia_pkg::ALU_SQRT:
        res_o = $signed(acc_q[63:0]);
      default:
        res_o = from_mag(neg_q, |acc_q[127:64+FB], acc_q[63+FB:FB],
                         neg_q && (|acc_q[FB-1:0]));
    endcase
  end

  assign prod_o     = acc_q;
  assign rsp_o.busy = busy_q;
  assign rsp_o.done = fin_q;

endmodule

// ----- design/kirchhoff_surface_integral_accumulator_unit.sv -----
// Kirchhoff surface integral accumulator over a stationary surface.
// in_i carries one quadrature point per item (position, normal, area weight,
// pressure and normal-derivative samples at window start and end, last flag).
// out_o carries one result per pass: the saturated Q32.32 partial integral of
// the window and the count of points off the observer whose emission time fell inside it.
// Configuration (observer, wave slowness, window) is written over the APB
// port, 64-bit data, register i at byte address 8*i; reads return the value.
// One point at a time: in_i.ready is high only while the unit is idle.
// A point outside the window stops after the emission-time check; one inside
// runs the full step sequence on the shared ALU, whose divider retires one
// quotient bit per cycle (96 per division, four divisions) and whose square root
// retires one result bit per cycle (64). Multiplies take four 32x32 partial products.
// The result of a last point is loaded into the output register; when that
// register is still full, the unit waits until out_o.ready takes it.
// Reset clears configuration to zero, the accumulator and count, and the output
// valid flag.
`include "kirchhoff_surface_integral_accumulator_unit_defines.svh"

module kirchhoff_surface_integral_accumulator_unit #(
  parameter int COUNT_BITS = ksia_pkg::COUNT_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ksia_in_if.sink     in_i,
  ksia_out_if.source  out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int FB = ksia_pkg::FRAC_BITS;

  logic signed [47:0] obs_x_q, obs_y_q, obs_z_q, obs_t_q, win_s_q, win_e_q;
  logic        [46:0] inv_c_q, inv_wl_q;

  ksia_pkg::state_e state_q, state_d;
  ksia_pkg::step_e  step_q, step_d;
  logic             issued_q;

  logic signed [63:0] dx_q, dy_q, dz_q, nx_q, ny_q, nz_q, w_q;
  logic signed [63:0] p0_q, q0_q, dp_q, dq_q;
  logic               last_q;
  logic        [127:0] ss_q;
  logic signed [63:0] r_q, tau_q, el_q, dot_q, cs_q, pt_q, p_q, pn_q, t1_q, tmp_q;

  logic signed [63:0]    sum_q;
  logic [COUNT_BITS-1:0] count_q;

  logic               out_valid_q;
  logic signed [63:0] out_sum_q;
  logic [23:0]        out_cnt_q;

  ksia_pkg::alu_req_t alu_req;
  ksia_pkg::alu_rsp_t alu_rsp;
  logic signed [63:0] alu_a, alu_b, alu_res;
  logic        [127:0] alu_prod;

  logic               in_fire, out_free, cfg_wr, in_win, use_alu, load_out;
  logic signed [63:0] inv_c_s, inv_wl_s;
  logic [63:0]        rcs;
  logic signed [63:0] tau_new;

  assign inv_c_s  = $signed({17'd0, inv_c_q});
  assign inv_wl_s = $signed({17'd0, inv_wl_q});

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      obs_x_q  <= '0;
      obs_y_q  <= '0;
      obs_z_q  <= '0;
      obs_t_q  <= '0;
      inv_c_q  <= '0;
      win_s_q  <= '0;
      win_e_q  <= '0;
      inv_wl_q <= '0;
    end else if (cfg_wr) begin
      unique case (ksia_pkg::reg_idx_e'(paddr[5:3]))
        ksia_pkg::REG_OBS_X:     obs_x_q  <= $signed(pwdata[47:0]);
        ksia_pkg::REG_OBS_Y:     obs_y_q  <= $signed(pwdata[47:0]);
        ksia_pkg::REG_OBS_Z:     obs_z_q  <= $signed(pwdata[47:0]);
        ksia_pkg::REG_OBS_T:     obs_t_q  <= $signed(pwdata[47:0]);
        ksia_pkg::REG_INV_C:     inv_c_q  <= pwdata[46:0];
        ksia_pkg::REG_WIN_START: win_s_q  <= $signed(pwdata[47:0]);
        ksia_pkg::REG_WIN_END:   win_e_q  <= $signed(pwdata[47:0]);
        ksia_pkg::REG_INV_WLEN:  inv_wl_q <= pwdata[46:0];
      endcase
    end
  end

  always_comb begin
    unique case (ksia_pkg::reg_idx_e'(paddr[5:3]))
      ksia_pkg::REG_OBS_X:     prdata = 64'(obs_x_q);
      ksia_pkg::REG_OBS_Y:     prdata = 64'(obs_y_q);
      ksia_pkg::REG_OBS_Z:     prdata = 64'(obs_z_q);
      ksia_pkg::REG_OBS_T:     prdata = 64'(obs_t_q);
      ksia_pkg::REG_INV_C:     prdata = {17'd0, inv_c_q};
      ksia_pkg::REG_WIN_START: prdata = 64'(win_s_q);
      ksia_pkg::REG_WIN_END:   prdata = 64'(win_e_q);
      ksia_pkg::REG_INV_WLEN:  prdata = {17'd0, inv_wl_q};
    endcase
  end

  // ---------------- shared ALU ----------------
  ksia_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .a_i    (alu_a),
    .b_i    (alu_b),
    .rad_i  (ss_q),
    .rsp_o  (alu_rsp),
    .res_o  (alu_res),
    .prod_o (alu_prod)
  );

  always_comb begin
    alu_req.op = ksia_pkg::ALU_FMUL;
    alu_a      = tmp_q;
    alu_b      = r_q;
    use_alu    = 1'b1;
    unique case (step_q)
      ksia_pkg::ST_SQX:  begin alu_req.op = ksia_pkg::ALU_WMUL; alu_a = dx_q; alu_b = dx_q; end
      ksia_pkg::ST_SQY:  begin alu_req.op = ksia_pkg::ALU_WMUL; alu_a = dy_q; alu_b = dy_q; end
      ksia_pkg::ST_SQZ:  begin alu_req.op = ksia_pkg::ALU_WMUL; alu_a = dz_q; alu_b = dz_q; end
      ksia_pkg::ST_SQRT: alu_req.op = ksia_pkg::ALU_SQRT;
      ksia_pkg::ST_RC:   begin alu_req.op = ksia_pkg::ALU_WMUL; alu_a = r_q; alu_b = inv_c_s; end
      ksia_pkg::ST_CHK:  use_alu = 1'b0;
      ksia_pkg::ST_DOTX: begin alu_a = dx_q; alu_b = nx_q; end
      ksia_pkg::ST_DOTY: begin alu_a = dy_q; alu_b = ny_q; end
      ksia_pkg::ST_DOTZ: begin alu_a = dz_q; alu_b = nz_q; end
      ksia_pkg::ST_CS:   begin alu_req.op = ksia_pkg::ALU_DIV; alu_a = dot_q; end
      ksia_pkg::ST_PT:   begin alu_a = dp_q; alu_b = inv_wl_s; end
      ksia_pkg::ST_PP:   begin alu_a = pt_q; alu_b = el_q; end
      ksia_pkg::ST_PNA:  begin alu_a = dq_q; alu_b = inv_wl_s; end
      ksia_pkg::ST_PNB:  alu_b = el_q;
      ksia_pkg::ST_AA:   begin alu_a = inv_c_s; alu_b = pt_q; end
      ksia_pkg::ST_AB:   alu_b = cs_q;
      ksia_pkg::ST_T1:   alu_req.op = ksia_pkg::ALU_DIV;
      ksia_pkg::ST_T2A:  begin alu_a = p_q; alu_b = cs_q; end
      ksia_pkg::ST_T2B:  alu_req.op = ksia_pkg::ALU_DIV;
      ksia_pkg::ST_T2C:  alu_req.op = ksia_pkg::ALU_DIV;
      ksia_pkg::ST_KM:   begin alu_a = ksia_pkg::sadd(t1_q, tmp_q); alu_b = ksia_pkg::K_FIX; end
      ksia_pkg::ST_TERM: alu_b = w_q;
      default:           use_alu = 1'b0;
    endcase
    alu_req.start = (state_q == ksia_pkg::S_CALC) && use_alu && !issued_q;
  end

  // emission time from the r * slowness product, clamped at 2^62
  always_comb begin
    rcs = alu_prod[63+FB:FB];
    if ((|alu_prod[127:64+FB]) || rcs > (64'd1 << 62)) rcs = 64'd1 << 62;
    tau_new = 64'(obs_t_q) - $signed(rcs);
  end

  assign in_win = (r_q != '0) && (tau_q > 64'(win_s_q)) && (tau_q < 64'(win_e_q));

  // ---------------- sequencer ----------------
  assign in_fire  = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == ksia_pkg::S_IDLE);

  always_comb begin
    state_d  = state_q;
    step_d   = step_q;
    load_out = 1'b0;
    unique case (state_q)
      ksia_pkg::S_IDLE: begin
        if (in_fire) begin
          state_d = ksia_pkg::S_CALC;
          step_d  = ksia_pkg::ST_SQX;
        end
      end
      ksia_pkg::S_CALC: begin
        if (step_q == ksia_pkg::ST_CHK) begin
          if (in_win) step_d = ksia_pkg::ST_DOTX;
          else state_d = ksia_pkg::S_FIN;
        end else if (alu_rsp.done) begin
          if (step_q == ksia_pkg::ST_TERM) state_d = ksia_pkg::S_FIN;
          else step_d = ksia_pkg::step_e'(step_q + 5'd1);
        end
      end
      ksia_pkg::S_FIN: begin
        if (!last_q) begin
          state_d = ksia_pkg::S_IDLE;
        end else if (out_free) begin
          state_d  = ksia_pkg::S_IDLE;
          load_out = 1'b1;
        end
      end
      default: state_d = ksia_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ksia_pkg::S_IDLE;
      step_q      <= ksia_pkg::ST_SQX;
      issued_q    <= 1'b0;
      sum_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      if (alu_req.start) issued_q <= 1'b1;
      else if (alu_rsp.done) issued_q <= 1'b0;
      if (state_q == ksia_pkg::S_CALC && step_q == ksia_pkg::ST_TERM && alu_rsp.done) begin
        sum_q <= ksia_pkg::sadd(sum_q, alu_res);
        if (count_q != '1) count_q <= count_q + COUNT_BITS'(1);
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
        sum_q       <= '0;
        count_q     <= '0;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_sum_q <= sum_q;
      out_cnt_q <= 24'(count_q);
    end
    if (in_fire) begin
      dx_q   <= 64'(obs_x_q) - 64'(in_i.point_x);
      dy_q   <= 64'(obs_y_q) - 64'(in_i.point_y);
      dz_q   <= 64'(obs_z_q) - 64'(in_i.point_z);
      nx_q   <= 64'(in_i.normal_x);
      ny_q   <= 64'(in_i.normal_y);
      nz_q   <= 64'(in_i.normal_z);
      w_q    <= $signed({17'd0, in_i.area_weight});
      p0_q   <= 64'(in_i.p_now);
      q0_q   <= 64'(in_i.pn_now);
      dp_q   <= 64'(in_i.p_next) - 64'(in_i.p_now);
      dq_q   <= 64'(in_i.pn_next) - 64'(in_i.pn_now);
      last_q <= in_i.last_point;
    end
    if (state_q == ksia_pkg::S_CALC && step_q == ksia_pkg::ST_CHK) begin
      el_q <= tau_q - 64'(win_s_q);
    end
    if (state_q == ksia_pkg::S_CALC && alu_rsp.done) begin
      unique case (step_q)
        ksia_pkg::ST_SQX:  ss_q  <= alu_prod;
        ksia_pkg::ST_SQY:  ss_q  <= ss_q + alu_prod;
        ksia_pkg::ST_SQZ:  ss_q  <= ss_q + alu_prod;
        ksia_pkg::ST_SQRT: r_q   <= alu_res;
        ksia_pkg::ST_RC:   tau_q <= tau_new;
        ksia_pkg::ST_DOTX: dot_q <= alu_res;
        ksia_pkg::ST_DOTY: dot_q <= ksia_pkg::sadd(dot_q, alu_res);
        ksia_pkg::ST_DOTZ: dot_q <= ksia_pkg::sadd(dot_q, alu_res);
        ksia_pkg::ST_CS:   cs_q  <= alu_res;
        ksia_pkg::ST_PT:   pt_q  <= alu_res;
        ksia_pkg::ST_PP:   p_q   <= ksia_pkg::sadd(p0_q, alu_res);
        ksia_pkg::ST_PNB:  pn_q  <= ksia_pkg::sadd(q0_q, alu_res);
        ksia_pkg::ST_AB:   tmp_q <= ksia_pkg::ssub(alu_res, pn_q);
        ksia_pkg::ST_T1:   t1_q  <= alu_res;
        ksia_pkg::ST_PNA, ksia_pkg::ST_AA, ksia_pkg::ST_T2A, ksia_pkg::ST_T2B,
        ksia_pkg::ST_T2C, ksia_pkg::ST_KM: tmp_q <= alu_res;
        default: ;
      endcase
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.partial_integral = out_sum_q;
  assign out_o.points_counted   = out_cnt_q;

  // ---------------- checks ----------------
  `KSIA_ASSERT_NOW(a_start_idle, alu_req.start, !alu_rsp.busy, "ALU started while busy")
  `KSIA_ASSERT_NOW(a_window_r, state_q == ksia_pkg::S_CALC && step_q == ksia_pkg::ST_CHK && in_win, r_q != '0, "point at observer taken into window")
  `KSIA_ASSERT_NEXT(a_clear, load_out, sum_q == '0 && count_q == '0 && out_valid_q, "accumulator not cleared after result")

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
  import ksia_pkg::*;

  localparam longint ONE       = 64'sd4294967296;        // 1.0 in Q16.32
  localparam longint MAX48     = 64'sd140737488355327;
  localparam longint MIN48     = -64'sd140737488355328;
  localparam longint MAXW      = 64'sd140737488355327;
  localparam int     TAIL      = 800;                    // > one in-window point
  localparam int     LIMIT     = 2500000;
  localparam int     LONG_HOLD = 3000;
  localparam logic signed [127:0] W_MAX = 128'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [127:0] W_MIN = -W_MAX - 1;

  typedef struct {
    logic signed [47:0] point_x, point_y, point_z;
    logic signed [47:0] normal_x, normal_y, normal_z;
    logic        [46:0] area_weight;
    logic signed [47:0] p_now, p_next, pn_now, pn_next;
    logic               last_point;
  } point_t;

  typedef struct {
    logic signed [63:0] integral;
    logic        [23:0] count;
  } window_sum_t;

  class integral_scoreboard;
    longint obs_x, obs_y, obs_z, obs_t, inv_c, win_start, win_end, inv_wlen;
    longint acc;
    longint hits;
    window_sum_t sums_due[$];
    int errors;

    function new();
      obs_x = 0; obs_y = 0; obs_z = 0; obs_t = 0;
      inv_c = 0; win_start = 0; win_end = 0; inv_wlen = 0;
      acc = 0; hits = 0; errors = 0;
    endfunction

    function void set_register(reg_idx_e idx, logic [63:0] v);
      logic signed [47:0] s;
      s = v[47:0];
      case (idx)
        REG_OBS_X:     obs_x = s;
        REG_OBS_Y:     obs_y = s;
        REG_OBS_Z:     obs_z = s;
        REG_OBS_T:     obs_t = s;
        REG_INV_C:     inv_c = {17'b0, v[46:0]};
        REG_WIN_START: win_start = s;
        REG_WIN_END:   win_end = s;
        REG_INV_WLEN:  inv_wlen = {17'b0, v[46:0]};
        default: ;
      endcase
    endfunction

    function longint sat(logic signed [127:0] v);
      if (v > W_MAX) return W_MAX[63:0];
      if (v < W_MIN) return W_MIN[63:0];
      return v[63:0];
    endfunction

    function longint fmul(longint a, longint b);
      logic signed [127:0] p;
      p = a * b;
      return sat(p >>> 32);
    endfunction

    // floor division, den > 0
    function longint fdiv(longint a, longint b);
      logic signed [127:0] num, den, q;
      num = a;
      num = num <<< 32;
      den = b;
      q = num / den;
      if (num < 0 && (num % den) != 0) q = q - 1;
      return sat(q);
    endfunction

    function longint sadd(longint a, longint b);
      logic signed [127:0] x, y;
      x = a;
      y = b;
      return sat(x + y);
    endfunction

    function longint ssub(longint a, longint b);
      logic signed [127:0] x, y;
      x = a;
      y = b;
      return sat(x - y);
    endfunction

    function logic [127:0] square(longint a);
      logic [63:0] m;
      m = (a < 0) ? -a : a;
      return {64'b0, m} * {64'b0, m};
    endfunction

    function logic [63:0] isqrt(logic [127:0] v);
      logic [63:0] res, c;
      res = '0;
      for (int i = 63; i >= 0; i--) begin
        c = res | (64'd1 << i);
        if (({64'b0, c} * {64'b0, c}) <= v) res = c;
      end
      return res;
    endfunction

    function void note_point(point_t it);
      longint dx, dy, dz, nx, ny, nz, w, p0, p1, q0, q1;
      longint r, tau, el, dot, cs, slope, pv, pnv, a, t1, t2, contrib;
      logic [127:0] rc;
      logic [63:0] rcs;
      window_sum_t e;
      dx = it.point_x; dx = obs_x - dx;
      dy = it.point_y; dy = obs_y - dy;
      dz = it.point_z; dz = obs_z - dz;
      nx = it.normal_x; ny = it.normal_y; nz = it.normal_z;
      w = {17'b0, it.area_weight};
      p0 = it.p_now; p1 = it.p_next; q0 = it.pn_now; q1 = it.pn_next;
      r = isqrt(square(dx) + square(dy) + square(dz));
      if (r > 0) begin
        rc = {64'b0, r} * {64'b0, inv_c};
        rcs = rc[95:32];
        if (rc[127:96] != 0 || rcs > 64'h4000_0000_0000_0000) rcs = 64'h4000_0000_0000_0000;
        tau = obs_t - longint'(rcs);
        if (tau > win_start && tau < win_end) begin
          el = tau - win_start;
          dot = sadd(sadd(fmul(dx, nx), fmul(dy, ny)), fmul(dz, nz));
          cs = fdiv(dot, r);
          slope = fmul(p1 - p0, inv_wlen);
          pv = sadd(p0, fmul(slope, el));
          pnv = sadd(q0, fmul(fmul(q1 - q0, inv_wlen), el));
          a = ssub(fmul(fmul(inv_c, slope), cs), pnv);
          t1 = fdiv(a, r);
          t2 = fdiv(fdiv(fmul(pv, cs), r), r);
          contrib = fmul(fmul(sadd(t1, t2), K_FIX), w);
          acc = sadd(acc, contrib);
          if (hits < (64'd1 << COUNT_BITS) - 1) hits++;
        end
      end
      if (it.last_point) begin
        e.integral = acc;
        e.count = hits[23:0];
        sums_due = {sums_due, e};
        acc = 0;
        hits = 0;
      end
    endfunction

    function void check_result(logic signed [63:0] integral, logic [23:0] count);
      window_sum_t e;
      if (sums_due.size() == 0) begin
        $display("%0t: result with nothing expected: integral %0d count %0d",
                 $time, integral, count);
        errors++;
        return;
      end
      e = sums_due.pop_front();
      if (integral !== e.integral) begin
        $display("%0t: partial_integral expected %0d actual %0d", $time, e.integral, integral);
        errors++;
      end
      if (count !== e.count) begin
        $display("%0t: points_counted expected %0d actual %0d", $time, e.count, count);
        errors++;
      end
    endfunction

    function int pending();
      return sums_due.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [5:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;
  int cycles = 0;
  int results_taken = 0;
  int points_sent = 0;

  ksia_in_if in_if ();
  ksia_out_if out_if ();
  integral_scoreboard sb = new();

  kirchhoff_surface_integral_accumulator_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always begin
    #6ns clk_i = 1'b1;
    #6ns clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    point_t it;
    if (rst_ni && in_if.valid && in_if.ready) begin
      it.point_x = in_if.point_x; it.point_y = in_if.point_y; it.point_z = in_if.point_z;
      it.normal_x = in_if.normal_x; it.normal_y = in_if.normal_y;
      it.normal_z = in_if.normal_z;
      it.area_weight = in_if.area_weight;
      it.p_now = in_if.p_now; it.p_next = in_if.p_next;
      it.pn_now = in_if.pn_now; it.pn_next = in_if.pn_next;
      it.last_point = in_if.last_point;
      sb.note_point(it);
    end
    if (rst_ni && out_if.valid && out_if.ready) begin
      sb.check_result(out_if.partial_integral, out_if.points_counted);
      results_taken <= results_taken + 1;
    end
  end

  // result side: random hold-off per item, one long hold to back the unit up
  initial begin
    int hold;
    out_if.ready = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (results_taken == 10) hold = LONG_HOLD;
      else if (results_taken % 20 < 5) hold = 0;
      else hold = $urandom_range(0, 14);
      if (hold > 0) begin
        out_if.ready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_if.valid) @(posedge clk_i);
    end
  end

  task automatic write_reg(reg_idx_e idx, logic [63:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 6'(idx) << 3;
    pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.set_register(idx, v);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_all(longint ox, longint oy, longint oz, longint ot, longint ic,
                           longint ws, longint we, longint iw);
    write_reg(REG_OBS_X, ox);
    write_reg(REG_OBS_Y, oy);
    write_reg(REG_OBS_Z, oz);
    write_reg(REG_OBS_T, ot);
    write_reg(REG_INV_C, ic);
    write_reg(REG_WIN_START, ws);
    write_reg(REG_WIN_END, we);
    write_reg(REG_INV_WLEN, iw);
  endtask

  // stop offering, wait for all sums, then let a non-last point finish
  // before touching registers
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (TAIL) @(posedge clk_i);
  endtask

  task automatic send_point(point_t it);
    int gap;
    gap = (points_sent % 150 < 30) ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.point_x <= it.point_x; in_if.point_y <= it.point_y; in_if.point_z <= it.point_z;
    in_if.normal_x <= it.normal_x; in_if.normal_y <= it.normal_y;
    in_if.normal_z <= it.normal_z;
    in_if.area_weight <= it.area_weight;
    in_if.p_now <= it.p_now; in_if.p_next <= it.p_next;
    in_if.pn_now <= it.pn_now; in_if.pn_next <= it.pn_next;
    in_if.last_point <= it.last_point;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    points_sent++;
  endtask

  function automatic point_t mk(longint px, longint py, longint pz, longint nx, longint ny,
                                longint nz, longint w, longint p0, longint p1, longint q0,
                                longint q1, bit last);
    point_t it;
    it.point_x = px[47:0]; it.point_y = py[47:0]; it.point_z = pz[47:0];
    it.normal_x = nx[47:0]; it.normal_y = ny[47:0]; it.normal_z = nz[47:0];
    it.area_weight = w[46:0];
    it.p_now = p0[47:0]; it.p_next = p1[47:0]; it.pn_now = q0[47:0]; it.pn_next = q1[47:0];
    it.last_point = last;
    return it;
  endfunction

  function automatic longint rnd_full();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return {{16{v[47]}}, v[47:0]};
  endfunction

  // value in [-span, span + 1) with a random fraction
  function automatic longint rnd_q(int span);
    return (longint'($urandom_range(0, 2 * span)) - span) * ONE + longint'($urandom);
  endfunction

  function automatic point_t rnd_point(bit noisy);
    if (noisy)
      return mk(rnd_full(), rnd_full(), rnd_full(), rnd_full(), rnd_full(), rnd_full(),
                rnd_full() & MAXW, rnd_full(), rnd_full(), rnd_full(), rnd_full(),
                $urandom_range(0, 7) == 0);
    return mk(rnd_q(8), rnd_q(8), rnd_q(8), rnd_q(1), rnd_q(1), rnd_q(1),
              longint'($urandom), rnd_q(100), rnd_q(100), rnd_q(100), rnd_q(100),
              $urandom_range(0, 7) == 0);
  endfunction

  task automatic send_random(int n);
    point_t it;
    for (int i = 0; i < n; i++) begin
      it = rnd_point($urandom_range(0, 99) < 15);
      if (i == n - 1) it.last_point = 1'b1;
      send_point(it);
    end
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.point_x = '0; in_if.point_y = '0; in_if.point_z = '0;
    in_if.normal_x = '0; in_if.normal_y = '0; in_if.normal_z = '0;
    in_if.area_weight = '0;
    in_if.p_now = '0; in_if.p_next = '0; in_if.pn_now = '0; in_if.pn_next = '0;
    in_if.last_point = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset configuration: empty window, nothing counted
    send_random(5);
    drain();

    write_all(0, 0, 0, 10 * ONE, ONE, 0, 20 * ONE, ONE / 20);
    send_point(mk(0, 0, 0, ONE, 0, 0, ONE, ONE, ONE, ONE, ONE, 0));  // point at observer
    send_point(mk(3 * ONE, 4 * ONE, 0, ONE, 0, 0, ONE, 2 * ONE, 5 * ONE, -ONE, 3 * ONE, 0));
    // normal used as given, not unit
    send_point(mk(-2 * ONE, ONE, ONE, 3 * ONE, -2 * ONE, 0, ONE / 2, ONE, 0, 0, ONE, 0));
    send_point(mk(ONE, ONE, ONE, 0, 0, ONE, ONE / 4, ONE, -ONE, ONE, ONE, 1));
    send_point(mk(MAX48, MAX48, MAX48, MIN48, MIN48, MIN48, MAXW, MAX48, MIN48, MIN48, MAX48,
                  0));
    send_point(mk(MIN48, MIN48, MIN48, MAX48, MAX48, MAX48, MAXW, MIN48, MAX48, MAX48, MIN48,
                  1));
    // accumulator overflow in both directions
    for (int i = 0; i < 3; i++)
      send_point(mk(ONE / 1024, 0, 0, MAX48, 0, 0, MAXW, MAX48, MIN48, MIN48, MAX48, i == 2));
    for (int i = 0; i < 3; i++)
      send_point(mk(ONE / 1024, 0, 0, MIN48, 0, 0, MAXW, MIN48, MAX48, MAX48, MIN48, i == 2));
    send_point(mk(ONE, -ONE, 2 * ONE, 0, ONE, 0, 0, 0, 0, 0, 0, 1));
    send_random(250);
    drain();

    // random configuration, reasonable half the time
    for (int k = 0; k < 2; k++) begin
      if ($urandom_range(0, 1))
        write_all(rnd_full(), rnd_full(), rnd_full(), rnd_full(), rnd_full() & MAXW,
                  rnd_full(), rnd_full(), rnd_full() & MAXW);
      else
        write_all(rnd_q(4), rnd_q(4), rnd_q(4), rnd_q(20), longint'($urandom_range(0, 3)) * ONE,
                  rnd_q(5), rnd_q(30), longint'($urandom));
      send_random(50);
      drain();
    end

    // extremes: widest window, with emission time first fixed at the observer time
    write_all(MAX48, MIN48, 0, 0, 0, MIN48, MAX48, MAXW);
    send_random(50);
    drain();
    write_all(MIN48, MAX48, MIN48, MAX48, MAXW, MIN48, MAX48, 1);
    send_random(50);
    drain();

    // reversed and empty windows
    write_all(0, 0, 0, 10 * ONE, ONE, 5 * ONE, 2 * ONE, ONE);
    send_random(25);
    drain();
    write_reg(REG_WIN_END, 5 * ONE);
    send_random(25);
    drain();

    write_all(ONE, -2 * ONE, ONE / 2, 30 * ONE, ONE / 2, 20 * ONE, 40 * ONE, ONE / 20);
    send_random(200);
    in_if.valid <= 1'b0;
    drain();

    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
